@@ src/jddm_pkg.sv @@
// Shared constants, types and tables of the joystick differential-drive mixer.
package jddm_pkg;

  localparam int JOY_MAX      = 100;
  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = ANGLE_BITS - 2;
  localparam int CORDIC_N     = 26;
  localparam int Z_BITS       = 28;
  localparam int CORDIC_SHIFT = 24;
  localparam int MOD_ONE      = 16384;
  localparam int MOD_P7       = 11469;
  localparam int MOD_SHIFT    = 14;
  localparam int JOY_W        = 8;
  localparam int SAT_W        = JOY_W + 1;
  localparam int SQ_BITS      = 15;
  localparam int ROOT_BITS    = 8;
  localparam int XW           = 34;
  localparam int ZW           = 29;
  localparam int MOD_W        = 17;
  localparam int SPEED_W      = 9;

  typedef logic signed [XW-1:0]      cvec_t;
  typedef logic signed [ZW-1:0]      zang_t;
  typedef logic signed [MOD_W-1:0]   modv_t;
  typedef logic signed [JOY_W-1:0]   joy_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef struct packed {
    logic [1:0]           q;
    logic                 pyz;
    cvec_t                x;
    cvec_t                y;
    zang_t                z;
    logic [SQ_BITS-1:0]   n;
    logic [ROOT_BITS-1:0] r;
  } cst_t;

  function automatic zang_t atan_of(input int i);
    zang_t v;
    case (i)
      0:  v = ZW'(33554432);
      1:  v = ZW'(19808338);
      2:  v = ZW'(10466182);
      3:  v = ZW'(5312797);
      4:  v = ZW'(2666708);
      5:  v = ZW'(1334654);
      6:  v = ZW'(667490);
      7:  v = ZW'(333765);
      8:  v = ZW'(166885);
      9:  v = ZW'(83443);
      10: v = ZW'(41722);
      11: v = ZW'(20861);
      12: v = ZW'(10430);
      13: v = ZW'(5215);
      14: v = ZW'(2608);
      15: v = ZW'(1304);
      16: v = ZW'(652);
      17: v = ZW'(326);
      18: v = ZW'(163);
      19: v = ZW'(81);
      20: v = ZW'(41);
      21: v = ZW'(20);
      22: v = ZW'(10);
      23: v = ZW'(5);
      24: v = ZW'(3);
      25: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Modifier breakpoints per quadrant; fin selects the far breakpoint.
  function automatic modv_t mod_pt(input logic [1:0] q, input logic right,
                                   input logic fin);
    modv_t v;
    case ({right, q, fin})
      4'b0_00_0: v = MOD_W'(MOD_ONE);
      4'b0_00_1: v = MOD_W'(MOD_P7);
      4'b0_01_0: v = MOD_W'(MOD_P7);
      4'b0_01_1: v = -MOD_W'(MOD_ONE);
      4'b0_10_0: v = -MOD_W'(MOD_ONE);
      4'b0_10_1: v = -MOD_W'(MOD_P7);
      4'b0_11_0: v = -MOD_W'(MOD_P7);
      4'b0_11_1: v = MOD_W'(MOD_ONE);
      4'b1_00_0: v = -MOD_W'(MOD_ONE);
      4'b1_00_1: v = MOD_W'(MOD_P7);
      4'b1_01_0: v = MOD_W'(MOD_P7);
      4'b1_01_1: v = MOD_W'(MOD_ONE);
      4'b1_10_0: v = MOD_W'(MOD_ONE);
      4'b1_10_1: v = -MOD_W'(MOD_P7);
      4'b1_11_0: v = -MOD_W'(MOD_P7);
      4'b1_11_1: v = -MOD_W'(MOD_ONE);
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/jddm_if.sv @@
// Valid/ready channel interfaces for joystick samples and motor speeds.
interface jddm_joy_if;
  import jddm_pkg::*;
  logic valid;
  logic ready;
  joy_t joy_x;
  joy_t joy_y;
  modport source(output valid, output joy_x, output joy_y, input ready);
  modport sink(input valid, input joy_x, input joy_y, output ready);
endinterface

interface jddm_speed_if;
  import jddm_pkg::*;
  logic   valid;
  logic   ready;
  speed_t left_speed;
  speed_t right_speed;
  modport source(output valid, output left_speed, output right_speed, input ready);
  modport sink(input valid, input left_speed, input right_speed, output ready);
endinterface

@@ src/jddm_front.sv @@
// Input stage: saturation, quadrant fold, CORDIC seed and sum of squares.
module jddm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jddm_pkg::joy_t joy_x,
  input  jddm_pkg::joy_t joy_y,
  output logic           out_valid,
  input  logic           out_ready,
  output jddm_pkg::cst_t out_data
);
  import jddm_pkg::*;

  logic signed [SAT_W-1:0]   xs, ys, px, py;
  logic signed [2*SAT_W-1:0] sx, sy;
  logic [1:0]                q;
  cst_t                      st;

  function automatic logic signed [SAT_W-1:0] sat(input joy_t v);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SAT_W'(JOY_MAX)) w = SAT_W'(JOY_MAX);
    if (w < -SAT_W'(JOY_MAX)) w = -SAT_W'(JOY_MAX);
    return w;
  endfunction

  always_comb begin
    xs = sat(joy_x);
    ys = sat(joy_y);
    if (xs > 0 && ys >= 0) begin
      q = 2'd0; px = xs; py = ys;
    end else if (xs <= 0 && ys > 0) begin
      q = 2'd1; px = ys; py = -xs;
    end else if (xs < 0 && ys <= 0) begin
      q = 2'd2; px = -xs; py = -ys;
    end else begin
      q = 2'd3; px = -ys; py = xs;
    end
    sx = xs * xs;
    sy = ys * ys;
    st.q   = q;
    st.pyz = (py == 0);
    st.x   = XW'(px) <<< CORDIC_SHIFT;
    st.y   = XW'(py) <<< CORDIC_SHIFT;
    st.z   = '0;
    st.n   = SQ_BITS'(sx + sy);
    st.r   = '0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= st;
    end
  end
endmodule

@@ src/jddm_cordic.sv @@
// CORDIC vectoring pipeline, one iteration per stage, with the square-root digits alongside.
module jddm_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jddm_pkg::cst_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jddm_pkg::cst_t out_data
);
  import jddm_pkg::*;

  logic v   [CORDIC_N+1];
  cst_t d   [CORDIC_N+1];
  logic rdy [CORDIC_N+1];

  assign v[0]   = in_valid;
  assign d[0]   = in_data;
  assign in_ready = rdy[0];
  assign rdy[CORDIC_N] = out_ready;
  assign out_valid = v[CORDIC_N];
  assign out_data  = d[CORDIC_N];

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_it
    cst_t nx;
    cvec_t dx, dy;
    logic [ROOT_BITS-1:0]   t;
    logic [2*ROOT_BITS-1:0] tt;

    assign rdy[i] = !v[i+1] || rdy[i+1];

    always_comb begin
      nx = d[i];
      dx = d[i].y >>> i;
      dy = d[i].x >>> i;
      if (d[i].y >= 0) begin
        nx.x = d[i].x + dx;
        nx.y = d[i].y - dy;
        if (!d[i].pyz) nx.z = d[i].z + atan_of(i);
      end else begin
        nx.x = d[i].x - dx;
        nx.y = d[i].y + dy;
        if (!d[i].pyz) nx.z = d[i].z - atan_of(i);
      end
      t  = '0;
      tt = '0;
      if (i < ROOT_BITS) begin
        t  = d[i].r | (ROOT_BITS'(1) << (ROOT_BITS - 1 - i));
        tt = t * t;
        if (tt <= (2*ROOT_BITS)'(d[i].n)) nx.r = t;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (rdy[i]) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && v[i]) begin
        d[i+1] <= nx;
      end
    end
  end
endmodule

@@ src/jddm_back.sv @@
// Modifier interpolation and speed scaling, two register stages.
module jddm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jddm_pkg::cst_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jddm_pkg::speed_t  left_speed,
  output jddm_pkg::speed_t  right_speed
);
  import jddm_pkg::*;

  localparam int PW = MOD_W + FRAC_BITS + 1;
  localparam int SW = MOD_W + ROOT_BITS + 1;
  localparam zang_t ZMAX = zang_t'((64'd1 << (Z_BITS - 2)) - 1);

  zang_t                  zc;
  logic [FRAC_BITS-1:0]   frac;
  logic signed [PW-1:0]   pl, pr;
  modv_t                  ml, mr;
  logic                   va;
  modv_t                  mod_l, mod_r;
  logic [ROOT_BITS-1:0]   mag;
  logic                   rdy_a;

  function automatic speed_t scale(input logic [ROOT_BITS-1:0] m, input modv_t md);
    logic signed [SW-1:0] p, s;
    p = $signed({1'b0, m}) * md;
    s = (p < 0) ? -((-p) >>> MOD_SHIFT) : (p >>> MOD_SHIFT);
    return s[SPEED_W-1:0];
  endfunction

  always_comb begin
    zc = in_data.z;
    if (zc < 0) zc = '0;
    if (zc > ZMAX) zc = ZMAX;
    frac = zc[Z_BITS-3:Z_BITS-ANGLE_BITS];
    pl = (mod_pt(in_data.q, 1'b0, 1'b1) - mod_pt(in_data.q, 1'b0, 1'b0))
         * $signed({1'b0, frac});
    pr = (mod_pt(in_data.q, 1'b1, 1'b1) - mod_pt(in_data.q, 1'b1, 1'b0))
         * $signed({1'b0, frac});
    ml = mod_pt(in_data.q, 1'b0, 1'b0) + MOD_W'(pl >>> FRAC_BITS);
    mr = mod_pt(in_data.q, 1'b1, 1'b0) + MOD_W'(pr >>> FRAC_BITS);
  end

  assign in_ready = !va || rdy_a;
  assign rdy_a    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) va <= in_valid;
      if (rdy_a) out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mod_l <= ml;
      mod_r <= mr;
      mag   <= in_data.r;
    end
    if (rdy_a && va) begin
      left_speed  <= scale(mag, mod_l);
      right_speed <= scale(mag, mod_r);
    end
  end
endmodule

@@ src/joystick_differential_drive_mixer.sv @@
// Joystick differential-drive mixer: one (x, y) sample in, left/right motor speeds out.
// Fully pipelined: one sample per clock unless stalled (1 input stage, 26 CORDIC
// iteration stages that also resolve the 8 square-root digits, then interpolation and
// speed-scaling stages). Back-pressure stalls per stage; bubbles are squeezed out.
module joystick_differential_drive_mixer (
  input  logic clk,
  input  logic rst,
  jddm_joy_if.sink     joy,
  jddm_speed_if.source speed
);
  import jddm_pkg::*;

  logic f_valid, f_ready, c_valid, c_ready;
  cst_t f_data, c_data;

  jddm_front u_front (
    .clk, .rst,
    .in_valid (joy.valid), .in_ready (joy.ready),
    .joy_x (joy.joy_x), .joy_y (joy.joy_y),
    .out_valid (f_valid), .out_ready (f_ready), .out_data (f_data)
  );

  jddm_cordic u_cordic (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
    .out_valid (c_valid), .out_ready (c_ready), .out_data (c_data)
  );

  jddm_back u_back (
    .clk, .rst,
    .in_valid (c_valid), .in_ready (c_ready), .in_data (c_data),
    .out_valid (speed.valid), .out_ready (speed.ready),
    .left_speed (speed.left_speed), .right_speed (speed.right_speed)
  );
endmodule
